// File: hw/rtl/clb_pkg.sv
`default_nettype none

package clb_pkg;

   // field widths of the transfer payloads
   localparam int FRAC_W   = 18;
   localparam int DIM_W    = 13;
   localparam int SLOT_W   = 16;
   localparam int NEED_W   = 17;
   localparam int CELL_W   = 12;
   localparam int STAT_W   = 3;
   localparam int PID_W    = 20;

   // csr port
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // register reset values
   localparam logic [DIM_W-1:0]  CELLS_RESET = DIM_W'(1);
   localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(8);

   // command codes
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_BIN   = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_STORED   = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_OUT_BOX  = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_GHOST    = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_NAN      = 3'd4;
   localparam logic [STAT_W-1:0] STATUS_CLEARED  = 3'd5;

   // saturation value of a cell counter
   localparam logic [SLOT_W-1:0] COUNT_MAX = {SLOT_W{1'b1}};

   // register index within the csr map
   typedef enum logic [1:0] {
      REG_CELLS_X = 2'd0,
      REG_CELLS_Y = 2'd1,
      REG_CELLS_Z = 2'd2,
      REG_SLOTS   = 2'd3
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      SEQ_INIT,
      SEQ_IDLE,
      SEQ_CLEAR,
      SEQ_MUL,
      SEQ_AXIS,
      SEQ_ZY,
      SEQ_LIN,
      SEQ_LOOK,
      SEQ_UPDATE,
      SEQ_RESULT
   } seq_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/cell_list_binning_core.sv
`default_nettype none

// Cell list binning core. Each bin transfer carries signed fixed-point box
// fractions (FRAC_BITS fraction bits); the core forms the floor cell coordinate
// per axis, wraps an index equal to the dimension to 0, builds the linear cell
// index x + cells_x*(y + cells_y*z) and does a read-modify-write of that cell's
// 16-bit occupancy counter, held in a single-port-write, registered-read memory
// of NUM_COUNTERS entries. One item is in flight at a time; a sequencer walks it
// through three multiply steps and the counter update. A NaN item goes straight
// to its result; an item out of box on an axis leaves after the range check.
// A clear command sweeps every counter, one entry a cycle. After reset the same
// sweep runs before the first item is taken; csr writes are taken at any time.
// The result register lets the next item enter while a result waits.

module cell_list_binning_core #(
   parameter int NUM_COUNTERS = 4096,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   // item input
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic signed [clb_pkg::FRAC_W-1:0]  req_frac_x,
   input  wire logic signed [clb_pkg::FRAC_W-1:0]  req_frac_y,
   input  wire logic signed [clb_pkg::FRAC_W-1:0]  req_frac_z,
   input  wire logic                               req_position_nan,
   input  wire logic                               req_is_ghost,
   input  wire logic [clb_pkg::PID_W-1:0]          req_particle_id,

   // result output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [clb_pkg::STAT_W-1:0]              rsp_status,
   output logic [clb_pkg::CELL_W-1:0]              rsp_cell_index,
   output logic [clb_pkg::SLOT_W-1:0]              rsp_slot,
   output logic [clb_pkg::NEED_W-1:0]              rsp_needed_capacity,
   output logic [clb_pkg::PID_W-1:0]               rsp_particle_echo,

   // csr port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [clb_pkg::CSR_AW-1:0]         csr_paddr,
   input  wire logic [clb_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [clb_pkg::CSR_DW-1:0]              csr_prdata,
   output logic                                    csr_pready
);

   import clb_pkg::*;

   localparam int AW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int PW = FRAC_W + DIM_W + 1;
   localparam int ZW = 2 * DIM_W + 1;
   localparam int LW = ZW + DIM_W + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_COUNTERS - 1);

   // configuration registers
   logic [DIM_W-1:0]  cells_x_ff, cells_y_ff, cells_z_ff;
   logic [SLOT_W-1:0] slots_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   // sequencer
   seq_state_type state_ff, state_in;
   logic          req_xfer;
   logic          out_free;
   logic          load_bin;
   logic          load_res;

   // item registers
   logic                     ghost_ff;
   logic [PID_W-1:0]         pid_ff;
   logic [STAT_W-1:0]        stat_ff;
   logic signed [FRAC_W-1:0] frac_ff [3];
   logic signed [PW-1:0]     prod_ff [3];
   logic signed [PW-1:0]     prod_in [3];
   logic [DIM_W-1:0]         coord_ff [3];
   logic [DIM_W-1:0]         coord_in [3];
   logic [DIM_W-1:0]         dim_eff [3];
   logic [2:0]               axis_bad;
   logic                     any_bad;
   logic [ZW-1:0]            zy_ff, zy_in;
   logic [LW-1:0]            lin_ff, lin_in;
   logic                     lin_oob;

   // counter memory
   logic [SLOT_W-1:0] cnt_mem [NUM_COUNTERS];
   logic [SLOT_W-1:0] rd_ff;
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;
   logic [AW-1:0]     lin_addr;
   logic [AW-1:0]     clr_addr_ff;
   logic              clr_last;

   // counter update
   logic              cnt_over;
   logic [NEED_W-1:0] cnt_need;
   logic [SLOT_W-1:0] cnt_next;
   logic [NEED_W-1:0] max_needed_ff, max_needed_in;

   // result register
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [NEED_W-1:0] rsp_need_ff;
   logic [PID_W-1:0]  rsp_pid_ff;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CELLS_RESET;
         cells_y_ff <= CELLS_RESET;
         cells_z_ff <= CELLS_RESET;
         slots_ff   <= SLOTS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CELLS_X: cells_x_ff <= csr_pwdata[DIM_W-1:0];
            REG_CELLS_Y: cells_y_ff <= csr_pwdata[DIM_W-1:0];
            REG_CELLS_Z: cells_z_ff <= csr_pwdata[DIM_W-1:0];
            REG_SLOTS:   slots_ff   <= csr_pwdata[SLOT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CELLS_X: csr_prdata = CSR_DW'(cells_x_ff);
         REG_CELLS_Y: csr_prdata = CSR_DW'(cells_y_ff);
         REG_CELLS_Z: csr_prdata = CSR_DW'(cells_z_ff);
         REG_SLOTS:   csr_prdata = CSR_DW'(slots_ff);
      endcase
   end

   // a zero dimension acts as one
   assign dim_eff[0] = (cells_x_ff == '0) ? DIM_W'(1) : cells_x_ff;
   assign dim_eff[1] = (cells_y_ff == '0) ? DIM_W'(1) : cells_y_ff;
   assign dim_eff[2] = (cells_z_ff == '0) ? DIM_W'(1) : cells_z_ff;

   // per-axis lanes: fraction times dimension, then floor and range check
   always_comb begin
      logic signed [PW-1:0] idx;
      logic signed [PW-1:0] dim_s;
      for (int i = 0; i < 3; i++) begin
         dim_s       = PW'($signed({1'b0, dim_eff[i]}));
         prod_in[i]  = PW'(frac_ff[i]) * dim_s;
         idx         = prod_ff[i] >>> FRAC_BITS;
         axis_bad[i] = (idx < 0) || (idx > dim_s);
         coord_in[i] = (idx == dim_s) ? '0 : idx[DIM_W-1:0];
      end
   end

   assign any_bad = |axis_bad;

   // linear index in two multiply steps
   assign zy_in    = ZW'(coord_ff[1]) + ZW'(dim_eff[1]) * ZW'(coord_ff[2]);
   assign lin_in   = LW'(coord_ff[0]) + LW'(dim_eff[0]) * LW'(zy_ff);
   assign lin_oob  = lin_ff >= LW'(NUM_COUNTERS);
   assign lin_addr = lin_ff[AW-1:0];

   // counter read-modify-write values
   assign cnt_over = rd_ff >= slots_ff;
   assign cnt_need = NEED_W'(rd_ff) + NEED_W'(1);
   assign cnt_next = (rd_ff == COUNT_MAX) ? rd_ff : rd_ff + SLOT_W'(1);
   assign max_needed_in = (cnt_over && (cnt_need > max_needed_ff)) ? cnt_need
                                                                   : max_needed_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_xfer = req_valid && req_ready;
   assign clr_last = clr_addr_ff == LAST_ADDR;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_INIT: begin
            if (clr_last) state_in = SEQ_IDLE;
         end
         SEQ_IDLE: begin
            if (req_xfer) begin
               priority if (req_cmd == CMD_CLEAR) state_in = SEQ_CLEAR;
               else if (req_position_nan)         state_in = SEQ_RESULT;
               else                               state_in = SEQ_MUL;
            end
         end
         SEQ_CLEAR: begin
            if (clr_last) state_in = SEQ_RESULT;
         end
         SEQ_MUL:  state_in = SEQ_AXIS;
         SEQ_AXIS: state_in = any_bad ? SEQ_RESULT : SEQ_ZY;
         SEQ_ZY:   state_in = SEQ_LIN;
         SEQ_LIN:  state_in = SEQ_LOOK;
         SEQ_LOOK: state_in = lin_oob ? SEQ_RESULT : SEQ_UPDATE;
         SEQ_UPDATE: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         SEQ_RESULT: begin
            if (out_free) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      load_bin  = 1'b0;
      load_res  = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: req_ready = 1'b1;
         SEQ_INIT, SEQ_CLEAR: mem_we = 1'b1;
         SEQ_LOOK: mem_re = !lin_oob;
         SEQ_UPDATE: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = lin_addr;
               mem_wdata = cnt_next;
               load_bin  = 1'b1;
            end
         end
         SEQ_RESULT: load_res = out_free;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_INIT;
         clr_addr_ff   <= '0;
         max_needed_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == SEQ_INIT || state_ff == SEQ_CLEAR) begin
            clr_addr_ff <= clr_last ? '0 : clr_addr_ff + AW'(1);
         end
         if (req_xfer && req_cmd == CMD_CLEAR) begin
            max_needed_ff <= '0;
         end else if (load_bin) begin
            max_needed_ff <= max_needed_in;
         end
      end
   end

   // item datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ghost_ff   <= req_is_ghost;
         pid_ff     <= req_particle_id;
         frac_ff[0] <= req_frac_x;
         frac_ff[1] <= req_frac_y;
         frac_ff[2] <= req_frac_z;
         stat_ff    <= (req_cmd == CMD_CLEAR) ? STATUS_CLEARED : STATUS_NAN;
      end
      if (state_ff == SEQ_MUL) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= prod_in[i];
      end
      if (state_ff == SEQ_AXIS) begin
         for (int i = 0; i < 3; i++) coord_ff[i] <= coord_in[i];
      end
      if ((state_ff == SEQ_AXIS && any_bad) || (state_ff == SEQ_LOOK && lin_oob)) begin
         stat_ff <= ghost_ff ? STATUS_GHOST : STATUS_OUT_BOX;
      end
      if (state_ff == SEQ_ZY) zy_ff <= zy_in;
      if (state_ff == SEQ_LIN) lin_ff <= lin_in;
   end

   // counter memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= cnt_mem[lin_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_bin || load_res) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_bin) begin
         rsp_status_ff <= cnt_over ? STATUS_OVERFLOW : STATUS_STORED;
         rsp_cell_ff   <= lin_ff[CELL_W-1:0];
         rsp_slot_ff   <= rd_ff;
         rsp_need_ff   <= max_needed_in;
         rsp_pid_ff    <= pid_ff;
      end else if (load_res) begin
         rsp_status_ff <= stat_ff;
         rsp_cell_ff   <= '0;
         rsp_slot_ff   <= '0;
         rsp_need_ff   <= max_needed_ff;
         rsp_pid_ff    <= pid_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_cell_index      = rsp_cell_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_needed_capacity = rsp_need_ff;
   assign rsp_particle_echo   = rsp_pid_ff;

endmodule

`default_nettype wire
